/* src/lwh_pkg.sv */
package lwh_pkg;

  localparam int unsigned NumOutBins = 11;
  localparam int unsigned CntW       = 7;
  localparam int unsigned ValW       = 16;
  localparam int unsigned CoordW     = 6;
  localparam int unsigned RadW       = 3;
  localparam int unsigned SizeW      = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgWindowRad   = 3'd2,
    CfgBinOffset   = 3'd3,
    CfgInvBinWidth = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ReqLoad  = 1'b0,
    ReqQuery = 1'b1
  } req_e;

  // one classified request passed from front to back
  typedef struct packed {
    logic              query;
    logic              bad;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [ValW-1:0]   value;
  } cmd_t;

  typedef logic [NumOutBins-1:0][CntW-1:0] counts_t;

  // one finished result
  typedef struct packed {
    counts_t counts;
    logic    bad;
  } res_t;

endpackage

/* src/lwh_front.sv */
module lwh_front
  import lwh_pkg::*;
#(
  parameter int unsigned MaxWidth  = 64,
  parameter int unsigned MaxHeight = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              req_type_i,
  input  logic [CoordW-1:0] col_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [ValW-1:0]   pixel_value_i,
  input  logic [SizeW-1:0]  width_i,
  input  logic [SizeW-1:0]  height_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  localparam int unsigned Depth = 2;

  cmd_t             fifo_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic [SizeW:0]   w_eff, h_eff;
  logic             bad;
  logic             wr_en, rd_en;
  cmd_t             cmd_in;

  // clamp image size to 1..max
  always_comb begin
    if (width_i == '0) begin
      w_eff = (SizeW+1)'(1);
    end else if (int'(width_i) > MaxWidth) begin
      w_eff = (SizeW+1)'(MaxWidth);
    end else begin
      w_eff = {1'b0, width_i};
    end
    if (height_i == '0) begin
      h_eff = (SizeW+1)'(1);
    end else if (int'(height_i) > MaxHeight) begin
      h_eff = (SizeW+1)'(MaxHeight);
    end else begin
      h_eff = {1'b0, height_i};
    end
  end

  assign bad = ({{(SizeW+1-CoordW){1'b0}}, col_i} >= w_eff) ||
               ({{(SizeW+1-CoordW){1'b0}}, row_i} >= h_eff);

  always_comb begin
    cmd_in.query = (req_type_i == ReqQuery);
    cmd_in.bad   = bad;
    cmd_in.col   = col_i;
    cmd_in.row   = row_i;
    cmd_in.value = pixel_value_i;
  end

  assign full_o      = (cnt_q == 2'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_ptr_q] <= cmd_in;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(Depth))
    else $error("command queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> (cnt_q == 2'(Depth)) || $past(rd_en))
    else $error("queue drained without a read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree on empty queue");

endmodule

/* src/lwh_back.sv */
module lwh_back
  import lwh_pkg::*;
#(
  parameter int unsigned Bins      = 11,
  parameter int unsigned MaxWidth  = 64,
  parameter int unsigned MaxHeight = 64,
  parameter int unsigned MaxRadius = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  logic [SizeW-1:0]  width_i,
  input  logic [SizeW-1:0]  height_i,
  input  logic [RadW-1:0]   radius_i,
  input  logic [ValW-1:0]   offset_i,
  input  logic [ValW-1:0]   inv_i,
  output logic              empty_o,
  input  logic              pop_i,
  output res_t              res_o
);

  localparam int unsigned XW    = $clog2(MaxWidth);
  localparam int unsigned YW    = $clog2(MaxHeight);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 2 ** AW;
  localparam int unsigned BinW  = $clog2(NumOutBins);
  localparam int unsigned WinW  = 5; // signed offset -7..7

  typedef enum logic [2:0] {
    StIdle, StWalk, StDrain, StDone
  } state_e;

  logic [ValW-1:0]   mem_q [Depth];
  logic [ValW-1:0]   rdata_q;
  state_e            state_q;
  counts_t           cnt_q;
  logic              bad_q;
  logic signed [WinW-1:0] dx_q, dy_q, rad_q;
  logic [CoordW-1:0] col_q, row_q;
  logic              rd_v_q, prod_v_q;
  logic signed [ValW+ValW+1:0] prod_q;
  res_t              out_q;
  logic              out_v_q;
  logic [SizeW:0]    w_eff, h_eff;
  logic [RadW-1:0]   r_eff;
  logic signed [SizeW+1:0] xs, ys;
  logic [XW-1:0]     x_cl;
  logic [YW-1:0]     y_cl;
  logic [AW-1:0]     raddr, waddr;
  logic              load_go, mem_rd;
  logic signed [ValW:0] diff;
  logic [BinW-1:0]   bin_idx;
  logic              last_pos;
  logic              out_free;

  always_comb begin
    if (width_i == '0) w_eff = (SizeW+1)'(1);
    else if (int'(width_i) > MaxWidth) w_eff = (SizeW+1)'(MaxWidth);
    else w_eff = {1'b0, width_i};
    if (height_i == '0) h_eff = (SizeW+1)'(1);
    else if (int'(height_i) > MaxHeight) h_eff = (SizeW+1)'(MaxHeight);
    else h_eff = {1'b0, height_i};
    r_eff = (radius_i > RadW'(MaxRadius)) ? RadW'(MaxRadius) : radius_i;
  end

  // replicate edge pixels
  always_comb begin
    xs = $signed({2'b00, {(SizeW-CoordW){1'b0}}, col_q}) + (SizeW+2)'(dx_q);
    ys = $signed({2'b00, {(SizeW-CoordW){1'b0}}, row_q}) + (SizeW+2)'(dy_q);
    if (xs < 0) x_cl = '0;
    else if (xs >= $signed({1'b0, w_eff})) x_cl = XW'(w_eff - 1'b1);
    else x_cl = XW'(xs);
    if (ys < 0) y_cl = '0;
    else if (ys >= $signed({1'b0, h_eff})) y_cl = YW'(h_eff - 1'b1);
    else y_cl = YW'(ys);
  end

  assign raddr    = {y_cl, x_cl};
  assign waddr    = {YW'(cmd_i.row), XW'(cmd_i.col)};
  assign last_pos = (dx_q == rad_q) && (dy_q == rad_q);
  assign mem_rd   = (state_q == StWalk);
  // output register can take a new result this cycle
  assign out_free = !out_v_q || pop_i;

  assign cmd_ready_o = (state_q == StIdle);
  assign load_go     = cmd_valid_i && cmd_ready_o && !cmd_i.query && !cmd_i.bad;

  always_ff @(posedge clk_i) begin
    if (load_go) mem_q[waddr] <= cmd_i.value;
    if (mem_rd) rdata_q <= mem_q[raddr];
  end

  // bin stage: one multiply registered, then clamp
  assign diff = $signed({rdata_q[ValW-1], rdata_q}) - $signed({offset_i[ValW-1], offset_i});
  always_ff @(posedge clk_i) begin
    prod_q <= $signed((ValW+ValW+2)'(diff)) * $signed((ValW+ValW+2)'({2'b00, inv_i}));
  end

  always_comb begin
    if (prod_q < 0) bin_idx = '0;
    else if (prod_q[ValW+ValW+1:16] > (ValW+2)'(Bins - 1)) bin_idx = BinW'(Bins - 1);
    else bin_idx = BinW'(prod_q[16 +: BinW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      bad_q    <= 1'b0;
      dx_q     <= '0;
      dy_q     <= '0;
      rad_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      out_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      rd_v_q   <= mem_rd;
      prod_v_q <= rd_v_q;
      if (prod_v_q && cnt_q[bin_idx] != '1) begin
        cnt_q[bin_idx] <= cnt_q[bin_idx] + 1'b1;
      end
      if ((state_q == StDone) && out_free) out_v_q <= 1'b1;
      else if (out_v_q && pop_i) out_v_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i && cmd_ready_o && cmd_i.query) begin
            cnt_q <= '0;
            bad_q <= cmd_i.bad;
            col_q <= cmd_i.col;
            row_q <= cmd_i.row;
            rad_q <= WinW'(r_eff);
            dx_q  <= -$signed(WinW'(r_eff));
            dy_q  <= -$signed(WinW'(r_eff));
            state_q <= cmd_i.bad ? StDone : StWalk;
          end
        end
        StWalk: begin
          if (last_pos) begin
            state_q <= StDrain;
          end else if (dx_q == rad_q) begin
            dx_q <= -rad_q;
            dy_q <= dy_q + 1'b1;
          end else begin
            dx_q <= dx_q + 1'b1;
          end
        end
        StDrain: begin
          if (!rd_v_q && !prod_v_q) state_q <= StDone;
        end
        StDone: begin
          // hold until the previous result is popped
          if (out_free) begin
            out_q.counts <= bad_q ? '0 : cnt_q;
            out_q.bad    <= bad_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign empty_o = !out_v_q;
  assign res_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !cmd_ready_o)
    else $error("command taken during a walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pop_i) |=> out_v_q && $stable(out_q))
    else $error("result lost before pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> !rd_v_q && !prod_v_q)
    else $error("result built while reads in flight");

endmodule

/* src/local_window_histogram.sv */
// channel  direction  handshake            payload
// input    in         push / full          req_type, col, row, pixel_value
// result   out        empty / pop          count_bin0..10, bad_coordinate
// config   in         cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
// a load is written as it leaves the command queue; a query walks its window one
// pixel per cycle from the single pixel memory read port; a query outside the
// image skips the walk.
// reset clears control and result registers and loads config defaults; the pixel memory is not cleared.
// a two-entry command queue lets input run ahead while a query walks.
// a finished result waits in an output register until popped; meanwhile loads
// go on and the next query walks, then holds until the register frees.
module local_window_histogram
  import lwh_pkg::*;
#(
  parameter int unsigned Bins      = 11,
  parameter int unsigned MaxWidth  = 64,
  parameter int unsigned MaxHeight = 64,
  parameter int unsigned MaxRadius = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                req_type_i,
  input  logic [CoordW-1:0]   col_i,
  input  logic [CoordW-1:0]   row_i,
  input  logic [ValW-1:0]     pixel_value_i,
  output logic                empty,
  input  logic                pop,
  output logic [CntW-1:0]     count_bin0_o,
  output logic [CntW-1:0]     count_bin1_o,
  output logic [CntW-1:0]     count_bin2_o,
  output logic [CntW-1:0]     count_bin3_o,
  output logic [CntW-1:0]     count_bin4_o,
  output logic [CntW-1:0]     count_bin5_o,
  output logic [CntW-1:0]     count_bin6_o,
  output logic [CntW-1:0]     count_bin7_o,
  output logic [CntW-1:0]     count_bin8_o,
  output logic [CntW-1:0]     count_bin9_o,
  output logic [CntW-1:0]     count_bin10_o,
  output logic                bad_coordinate_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [SizeW-1:0] width_q, height_q;
  logic [RadW-1:0]  radius_q;
  logic [ValW-1:0]  offset_q, inv_q;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(64);
      height_q <= SizeW'(64);
      radius_q <= RadW'(5);
      offset_q <= 16'hFD00;
      inv_q    <= 16'd427;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[SizeW-1:0];
        CfgWindowRad:   radius_q <= cfg_data_i[RadW-1:0];
        CfgBinOffset:   offset_q <= cfg_data_i;
        CfgInvBinWidth: inv_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lwh_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni,
    .push_i        (push),
    .full_o        (full),
    .req_type_i, .col_i, .row_i, .pixel_value_i,
    .width_i       (width_q),
    .height_i      (height_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  lwh_back #(
    .Bins(Bins), .MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxRadius(MaxRadius)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .width_i     (width_q),
    .height_i    (height_q),
    .radius_i    (radius_q),
    .offset_i    (offset_q),
    .inv_i       (inv_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign count_bin0_o     = res.counts[0];
  assign count_bin1_o     = res.counts[1];
  assign count_bin2_o     = res.counts[2];
  assign count_bin3_o     = res.counts[3];
  assign count_bin4_o     = res.counts[4];
  assign count_bin5_o     = res.counts[5];
  assign count_bin6_o     = res.counts[6];
  assign count_bin7_o     = res.counts[7];
  assign count_bin8_o     = res.counts[8];
  assign count_bin9_o     = res.counts[9];
  assign count_bin10_o    = res.counts[10];
  assign bad_coordinate_o = res.bad;

endmodule
